FILE: src/w8ml_pkg.sv
// Package for the window-8 match/literal encoder.
// Holds the code widths, queue sizing and the queue entry type.
// Used by every module of the block; depends on nothing.
package w8ml_pkg;

  // Width of one packed output byte.
  localparam int unsigned BYTE_BITS = 8;
  // A literal code is one flag bit followed by the 8-bit byte.
  localparam int unsigned LIT_BITS = 9;
  // Width of a code length field (holds up to LIT_BITS).
  localparam int unsigned NBITS_W = 4;
  // Bit buffer of the packer: up to two full bytes.
  localparam int unsigned BUF_BITS = 2 * BYTE_BITS;
  // Width of the packer bit count (holds up to BUF_BITS).
  localparam int unsigned CNT_W = $clog2(BUF_BITS + 1);
  // Default history depth.
  localparam int unsigned DEFAULT_WINDOW_DEPTH = 8;
  // Entries in the queue between the search and the packer.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Opcodes of an input item.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // One classified item: a code to pack, or a flush request.
  typedef struct packed {
    logic                 flush;
    logic [LIT_BITS-1:0]  code;
    logic [NBITS_W-1:0]   nbits;
  } q_entry_t;

  // Status of the packer, seen by the top level.
  typedef struct packed {
    logic             pop;
    logic [CNT_W-1:0] bit_count;
  } back_status_t;

endpackage

FILE: src/w8ml_front.sv
// Front part of the encoder: history window search and code forming.
// Depends on w8ml_pkg; writes classified entries into the queue.
module w8ml_front
  import w8ml_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           opcode_i,
  input  logic [7:0]     data_byte_i,
  output q_entry_t       entry_o
);

  localparam int unsigned DIST_BITS = (WINDOW_DEPTH <= 2) ? 1 : $clog2(WINDOW_DEPTH);
  localparam int unsigned FILL_W    = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned MATCH_BITS = 1 + DIST_BITS;

  logic [7:0]           hist_q [WINDOW_DEPTH];
  logic [FILL_W-1:0]    fill_q;
  logic [FILL_W-1:0]    fill_d;
  logic [WINDOW_DEPTH-1:0] hit;
  logic                 any_hit;
  logic [DIST_BITS-1:0] hit_dist;

  // Compare every valid history entry with the incoming byte.
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      hit[i] = (FILL_W'(i) < fill_q) && (hist_q[i] == data_byte_i);
    end
  end

  // Priority pick: the newest matching entry wins.
  always_comb begin
    hit_dist = '0;
    any_hit  = 1'b0;
    for (int i = WINDOW_DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_dist = DIST_BITS'(i);
        any_hit  = 1'b1;
      end
    end
  end

  // Form the queue entry for the current item.
  always_comb begin
    entry_o.flush = (opcode_i == OP_END);
    if (any_hit) begin
      entry_o.code  = LIT_BITS'(hit_dist);
      entry_o.nbits = NBITS_W'(MATCH_BITS);
    end else begin
      entry_o.code  = {1'b1, data_byte_i};
      entry_o.nbits = NBITS_W'(LIT_BITS);
    end
  end

  // History fill count; an end item starts a fresh stream.
  always_comb begin
    fill_d = fill_q;
    if (accept_i) begin
      if (opcode_i == OP_END) begin
        fill_d = '0;
      end else if (fill_q < FILL_W'(WINDOW_DEPTH)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // History shift line, newest byte in entry 0.
  always_ff @(posedge clk_i) begin
    if (accept_i && (opcode_i == OP_DATA)) begin
      hist_q[0] <= data_byte_i;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

endmodule

FILE: src/w8ml_queue.sv
// Short queue between the search front and the bit packer.
// Depends on w8ml_pkg for the entry type and depth.
module w8ml_queue
  import w8ml_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  q_entry_t          push_data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output q_entry_t          head_o,
  output logic [QCNT_W-1:0] count_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH <= 2) ? 1 : $clog2(QUEUE_DEPTH);

  q_entry_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q;
  logic [PTR_W-1:0]    rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/w8ml_back.sv
// Back part of the encoder: packs codes MSB-first into bytes and flushes.
// Depends on w8ml_pkg; drives the output register of the block.
module w8ml_back
  import w8ml_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  q_entry_t     q_head_i,
  output back_status_t status_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [7:0]   out_byte_o,
  output logic         last_o
);

  logic [BUF_BITS-1:0] bits_q, bits_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                ov_q, ov_d;
  logic [7:0]          byte_q, byte_d;
  logic                last_q, last_d;
  logic                pop;
  logic                slot_free;
  logic [BUF_BITS-1:0] code_al;
  logic [BUF_BITS-1:0] merged_bits;
  logic [CNT_W-1:0]    merged_cnt;
  logic [7:0]          pad;

  assign slot_free = !ov_q || out_ready_i;

  // New code left-aligned under the bits already held.
  always_comb begin
    code_al = ({q_head_i.code, (BUF_BITS - LIT_BITS)'(0)}
               << (NBITS_W'(LIT_BITS) - q_head_i.nbits)) >> cnt_q;
    merged_bits = bits_q | code_al;
    merged_cnt  = cnt_q + CNT_W'(q_head_i.nbits);
    pad         = 8'hFF >> cnt_q[2:0];
  end

  // Packer step: drain a full byte, else take the next queue entry.
  always_comb begin
    bits_d = bits_q;
    cnt_d  = cnt_q;
    ov_d   = ov_q && !out_ready_i;
    byte_d = byte_q;
    last_d = last_q;
    pop    = 1'b0;
    if (cnt_q >= CNT_W'(BYTE_BITS)) begin
      if (slot_free) begin
        ov_d   = 1'b1;
        byte_d = bits_q[BUF_BITS-1 -: BYTE_BITS];
        last_d = 1'b0;
        bits_d = bits_q << BYTE_BITS;
        cnt_d  = cnt_q - CNT_W'(BYTE_BITS);
      end
    end else if (q_valid_i) begin
      if (q_head_i.flush) begin
        if (cnt_q == '0) begin
          pop = 1'b1;
        end else if (slot_free) begin
          pop    = 1'b1;
          ov_d   = 1'b1;
          byte_d = bits_q[BUF_BITS-1 -: BYTE_BITS] | pad;
          last_d = 1'b1;
          bits_d = '0;
          cnt_d  = '0;
        end
      end else begin
        pop = 1'b1;
        if ((merged_cnt >= CNT_W'(BYTE_BITS)) && slot_free) begin
          ov_d   = 1'b1;
          byte_d = merged_bits[BUF_BITS-1 -: BYTE_BITS];
          last_d = 1'b0;
          bits_d = merged_bits << BYTE_BITS;
          cnt_d  = merged_cnt - CNT_W'(BYTE_BITS);
        end else begin
          bits_d = merged_bits;
          cnt_d  = merged_cnt;
        end
      end
    end
  end

  // Bits below the count are kept at zero, so the buffer is reset too.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      bits_q <= bits_d;
      cnt_q  <= cnt_d;
      ov_q   <= ov_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o        = ov_q;
  assign out_byte_o         = byte_q;
  assign last_o             = last_q;
  assign status_o.pop       = pop;
  assign status_o.bit_count = cnt_q;

endmodule

FILE: src/window8_match_literal_encoder_top.sv
// Window-8 match/literal encoder, top level.
// Throughput: one item per cycle into the queue while it is not full; the packer takes
// an entry only below a full byte; a full byte waits on the byte-wide output register.
// Reset clears the fill count, queue, packer bits and output valid; history is not cleared.
// Depends on w8ml_pkg, w8ml_front, w8ml_queue and w8ml_back.
module window8_match_literal_encoder_top
  import w8ml_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic              accept;
  logic              q_full;
  logic              q_valid;
  q_entry_t          front_entry;
  q_entry_t          q_head;
  logic [QCNT_W-1:0] q_count;
  back_status_t      back_status;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  // Window search and code forming.
  w8ml_front #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .opcode_i   (opcode_i),
    .data_byte_i(data_byte_i),
    .entry_o    (front_entry)
  );

  // Decoupling queue.
  w8ml_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_data_i(front_entry),
    .pop_i      (back_status.pop),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .count_o    (q_count)
  );

  // Bit packer and output register.
  w8ml_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .status_o   (back_status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

  // The packer only takes an entry that the queue holds.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.pop |-> (q_count != '0))
    else $error("packer popped an empty queue");

  // The bit buffer never holds more than two bytes.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.bit_count <= CNT_W'(BUF_BITS))
    else $error("packer bit count overflow");

  // A final byte always carries at least one pad bit.
  a_last_padded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> out_byte_o[0])
    else $error("final byte without pad bit");

  // A flush of a partial byte leaves the packer empty.
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_status.pop && q_valid && q_head.flush) |=> (back_status.bit_count == '0))
    else $error("flush left bits in the packer");

endmodule
